// ===== sv/mips_raw_hazard_nop_inserter_macros.svh =====
// ----------------------------------------------------------------------------
// MIPS RAW hazard NOP inserter assertion macros
// Shared immediate and next-cycle property checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef MIPS_RAW_HAZARD_NOP_INSERTER_MACROS_SVH
`define MIPS_RAW_HAZARD_NOP_INSERTER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define HZD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define HZD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/hzd_pkg.sv =====
// ----------------------------------------------------------------------------
// Hazard NOP inserter package
// Shared opcodes, the job type passed from front to back, and hazard decode.
// ----------------------------------------------------------------------------
package hzd_pkg;

    localparam logic [5:0]  OP_SPECIAL = 6'b000000;
    localparam logic [5:0]  OP_J       = 6'b000010;
    localparam logic [5:0]  OP_JAL     = 6'b000011;
    localparam logic [31:0] NOP_WORD   = 32'h0000_0000;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  nops;
        logic        last;
    } job_t;

    function automatic logic is_jump(input logic [31:0] w);
        return (w[31:26] == OP_J) || (w[31:26] == OP_JAL);
    endfunction

    function automatic logic [4:0] dest_reg(input logic [31:0] w);
        return (w[31:26] == OP_SPECIAL) ? w[15:11] : w[20:16];
    endfunction

    function automatic logic reads_reg(input logic [31:0] f, input logic [4:0] rd);
        logic hit;
        if (is_jump(f))
            hit = 1'b0;
        else if (f[31:26] == OP_SPECIAL)
            hit = (f[25:21] == rd) || (f[20:16] == rd);
        else
            hit = (f[25:21] == rd);
        return hit;
    endfunction

    function automatic logic [1:0] nop_count(input logic [31:0] w,
                                             input logic [31:0] f1,
                                             input logic [31:0] f2);
        logic [4:0] rd;
        logic [1:0] n;
        rd = dest_reg(w);
        if (is_jump(w))
            n = 2'd0;
        else if (reads_reg(f1, rd))
            n = 2'd2;
        else if (reads_reg(f2, rd))
            n = 2'd1;
        else
            n = 2'd0;
        return n;
    endfunction

endpackage

// ===== sv/hzd_front.sv =====
// ----------------------------------------------------------------------------
// Hazard NOP inserter front end: holds the lookahead window and accepts words.
// Issues one classified job a cycle while the job queue has room to take it.
// ----------------------------------------------------------------------------
module hzd_front
    import hzd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_word,
    input  logic        in_end,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);

    logic [31:0] p_reg [0:2];
    logic [31:0] p_next [0:2];
    logic [1:0]  fill_reg, fill_next;
    logic [1:0]  k_reg, k_next;
    logic        end_reg, end_next;
    logic        busy_reg, busy_next;

    logic [31:0] cur_w, f1_w, f2_w;
    logic        last_job, issue, done, accept;
    logic [31:0] win0, win1;
    logic [1:0]  wfill;

    always_comb
    begin
        cur_w = NOP_WORD;
        f1_w  = NOP_WORD;
        f2_w  = NOP_WORD;
        unique case (k_reg)
            2'd0:
            begin
                cur_w = p_reg[0];
                f1_w  = (fill_reg > 2'd1) ? p_reg[1] : NOP_WORD;
                f2_w  = (fill_reg > 2'd2) ? p_reg[2] : NOP_WORD;
            end
            2'd1:
            begin
                cur_w = p_reg[1];
                f1_w  = (fill_reg > 2'd2) ? p_reg[2] : NOP_WORD;
            end
            2'd2:
            begin
                cur_w = p_reg[2];
            end
            default:
            begin
                cur_w = NOP_WORD;
            end
        endcase
    end

    assign last_job  = end_reg ? (k_reg == 2'(fill_reg - 2'd1)) : 1'b1;
    assign job.word  = cur_w;
    assign job.nops  = nop_count(cur_w, f1_w, f2_w);
    assign job.last  = last_job;
    assign job_valid = busy_reg;
    assign issue     = busy_reg && job_ready;
    assign done      = issue && last_job;
    assign in_ready  = !busy_reg || done;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        if (busy_reg)
        begin
            win0  = p_reg[1];
            win1  = p_reg[2];
            wfill = end_reg ? 2'd0 : 2'd2;
        end
        else
        begin
            win0  = p_reg[0];
            win1  = p_reg[1];
            wfill = fill_reg;
        end
    end

    always_comb
    begin
        p_next[0] = p_reg[0];
        p_next[1] = p_reg[1];
        p_next[2] = p_reg[2];
        fill_next = fill_reg;
        k_next    = k_reg;
        end_next  = end_reg;
        busy_next = busy_reg;
        if (issue && !done)
            k_next = 2'(k_reg + 2'd1);
        if (done)
        begin
            p_next[0] = win0;
            p_next[1] = win1;
            fill_next = wfill;
            busy_next = 1'b0;
        end
        if (accept)
        begin
            p_next[0] = win0;
            p_next[1] = win1;
            unique case (wfill)
                2'd0:    p_next[0] = in_word;
                2'd1:    p_next[1] = in_word;
                default: p_next[2] = in_word;
            endcase
            fill_next = 2'(wfill + 2'd1);
            end_next  = in_end;
            k_next    = 2'd0;
            busy_next = (wfill == 2'd2) || in_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
            k_reg    <= 2'd0;
            end_reg  <= 1'b0;
            busy_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            k_reg    <= k_next;
            end_reg  <= end_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg[0] <= p_next[0];
        p_reg[1] <= p_next[1];
        p_reg[2] <= p_next[2];
    end

endmodule

// ===== sv/hzd_fifo.sv =====
// ----------------------------------------------------------------------------
// Hazard NOP inserter job queue
// Small first-in first-out buffer of classified jobs between front and back.
// ----------------------------------------------------------------------------
module hzd_fifo
    import hzd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic ready,
    input  job_t wr_data,
    output logic valid,
    input  logic pop,
    output job_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign ready   = (count_reg != CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && ready;
    assign do_pop  = pop && valid;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        if (do_push && !do_pop)
            count_next = CNT_W'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = CNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== sv/hzd_back.sv =====
// ----------------------------------------------------------------------------
// Hazard NOP inserter back end
// Expands each job into its word and trailing NOPs through an output register.
// ----------------------------------------------------------------------------
module hzd_back
    import hzd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_pop,
    input  job_t        q_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_word,
    output logic        out_nop,
    output logic        out_last
);

    job_t        job_reg, job_next;
    logic        job_valid_reg, job_valid_next;
    logic [1:0]  phase_reg, phase_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_word_reg, out_word_next;
    logic        out_nop_reg, out_nop_next;
    logic        out_last_reg, out_last_next;

    logic        load_out, emit, final_elem;

    assign load_out   = !out_valid_reg || out_ready;
    assign emit       = load_out && job_valid_reg;
    assign final_elem = (phase_reg == job_reg.nops);
    assign q_pop      = q_valid && (!job_valid_reg || (emit && final_elem));

    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_nop_next   = out_nop_reg;
        out_last_next  = out_last_reg;

        if (out_ready)
            out_valid_next = 1'b0;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_word_next  = (phase_reg == 2'd0) ? job_reg.word : NOP_WORD;
            out_nop_next   = (phase_reg != 2'd0);
            out_last_next  = final_elem && job_reg.last;
            phase_next     = 2'(phase_reg + 2'd1);
            if (final_elem)
                job_valid_next = 1'b0;
        end
        if (q_pop)
        begin
            job_next       = q_data;
            job_valid_next = 1'b1;
            phase_next     = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_word_reg <= out_word_next;
        out_nop_reg  <= out_nop_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_nop   = out_nop_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== sv/mips_raw_hazard_nop_inserter.sv =====
// ----------------------------------------------------------------------------
// MIPS RAW hazard NOP inserter
// Re-emits instruction words with zero NOPs after read-after-write hazards.
// ----------------------------------------------------------------------------
// After the input word that completes a run is accepted, its first word passes through
// the front window registers, the job queue, the back-end job register and the output
// register. Output runs at one result word per cycle while m_tready is high and the
// queue holds jobs; an input word yields one to three output words, itself plus NOPs.
// Reset clears the lookahead window, the job queue and the output register.
// ----------------------------------------------------------------------------
`include "mips_raw_hazard_nop_inserter_macros.svh"

module mips_raw_hazard_nop_inserter
    import hzd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // instr_word[31:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_word[31:0]
    output logic        m_tuser,   // is_inserted_nop
    output logic        m_tlast
);

    job_t front_job, q_job;
    logic q_push, q_ready, q_valid, q_pop;

    hzd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (s_tdata),
        .in_end    (s_tlast),
        .job_valid (q_push),
        .job_ready (q_ready),
        .job       (front_job)
    );

    hzd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .ready   (q_ready),
        .wr_data (front_job),
        .valid   (q_valid),
        .pop     (q_pop),
        .rd_data (q_job)
    );

    hzd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_job),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_tdata),
        .out_nop   (m_tuser),
        .out_last  (m_tlast)
    );

    `HZD_ASSERT_NOW(a_nop_is_zero, clk, rst_n, m_tvalid && m_tuser,
        m_tdata == NOP_WORD, "Inserted NOP is not zero.")
    `HZD_ASSERT_NOW(a_pop_has_job, clk, rst_n, q_pop, q_valid,
        "Job queue popped while empty.")
    `HZD_ASSERT_NOW(a_take_when_idle, clk, rst_n, !q_push, s_tready,
        "Front stalled with no job pending.")
    `HZD_ASSERT_NEXT(a_job_held, clk, rst_n, q_push && !q_ready, q_push,
        "Front dropped a job while the queue was full.")

endmodule
